### sv/serial_bus_device_protocol_assert.svh
// Assertion macros used by the checker file.
`ifndef SERIAL_BUS_DEVICE_PROTOCOL_ASSERT_SVH
`define SERIAL_BUS_DEVICE_PROTOCOL_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/sbdp_pkg.sv
// ----------------------------------------------------------------------------
// Serial bus device package
// Phase, request, register, status and address codes and timing constants.
// ----------------------------------------------------------------------------
package sbdp_pkg;
    localparam int CHANNELS_DEF = 16;

    localparam logic [4:0] PH_PRE0  = 5'd0;
    localparam logic [4:0] PH_PRE1  = 5'd1;
    localparam logic [4:0] PH_PRE2  = 5'd2;
    localparam logic [4:0] PH_READY = 5'd3;
    localparam logic [4:0] PH_EOI   = 5'd4;
    localparam logic [4:0] PH_EOIW  = 5'd5;
    localparam logic [4:0] PH_BIT0  = 5'd6;
    localparam logic [4:0] PH_BIT7W = 5'd21;
    localparam logic [4:0] PH_DONE0 = 5'd22;
    localparam logic [4:0] PH_DONE1 = 5'd23;
    localparam logic [4:0] PH_FERR0 = 5'd24;
    localparam logic [4:0] PH_FERR1 = 5'd25;

    localparam logic [2:0] REQ_NONE     = 3'd0;
    localparam logic [2:0] REQ_LISTALK  = 3'd1;
    localparam logic [2:0] REQ_CLOSE    = 3'd2;
    localparam logic [2:0] REQ_OPEN     = 3'd3;
    localparam logic [2:0] REQ_UNLISTEN = 3'd4;
    localparam logic [2:0] REQ_UNTALK   = 3'd5;
    localparam logic [2:0] REQ_WRITE    = 3'd6;
    localparam logic [2:0] REQ_READ     = 3'd7;

    localparam logic [0:0] REG_DEVNUM = 1'd0;
    localparam logic [0:0] REG_ENABLE = 1'd1;

    localparam logic [7:0] ST_OK  = 8'h00;
    localparam logic [7:0] ST_EOF = 8'h40;
    localparam logic [7:0] ADDR_UNLISTEN = 8'h3f;
    localparam logic [7:0] ADDR_UNTALK   = 8'h5f;
    localparam logic [3:0] SEC_DATA  = 4'h6;
    localparam logic [3:0] SEC_CLOSE = 4'he;
    localparam logic [3:0] SEC_OPEN  = 4'hf;

    localparam logic [31:0] T_PRE    = 32'd100;
    localparam logic [31:0] T_READY  = 32'd200;
    localparam logic [31:0] T_EOI    = 32'd80;
    localparam logic [31:0] T_TALKW  = 32'd130;
    localparam logic [31:0] T_BIT    = 32'd90;
    localparam logic [31:0] T_ACK    = 32'd1000;
    localparam logic [31:0] T_FERR   = 32'd100;
    localparam logic [31:0] T_PRELOAD = 32'd60;
endpackage

### sv/serial_bus_device_protocol.sv
// ----------------------------------------------------------------------------
// Serial bus device protocol engine
// One device on an ATN/CLK/DATA serial bus, one sample a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage: each input request carries one bus sample (time stamp in
// microseconds, ATN, CLK and DATA levels) together with the host's status
// and byte answer for whatever host request that sample raises. Each input
// request yields exactly one output request with the line releases, the host
// request code, its secondary address and data byte, and the mode flags.
// The sample is processed in the cycle it is accepted and the result sits in
// the output register at the next edge. The block takes one request per
// cycle unless stalled; the protocol state update is a single pass of short
// logic feeding the state registers. When the receiver stalls, one result is
// held in the output register and the input side stays open only if that
// register is being emptied in the same cycle. Reset clears the state, the
// status table, and sets device number 8 with the device disabled. The
// configuration port is APB-style; register 0 is the device number and
// register 1 the enable bit.
module serial_bus_device_protocol #(
    parameter int CHANNELS = sbdp_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_time_now,
    input  logic        i_atn_line,
    input  logic        i_clk_line,
    input  logic        i_data_line,
    input  logic [7:0]  i_host_status,
    input  logic [7:0]  i_host_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_clk_release,
    output logic        o_data_release,
    output logic [2:0]  o_host_request,
    output logic [7:0]  o_request_secondary,
    output logic [7:0]  o_request_data,
    output logic        o_is_listening,
    output logic        o_is_talking
);
    localparam int CW = $clog2(CHANNELS);

    logic [3:0]  r_devnum;
    logic        r_enabled;
    logic [4:0]  r_phase, n_phase;
    logic        r_talk, n_talk, r_listen, n_listen, r_atn, n_atn;
    logic [7:0]  r_shift, n_shift, r_prim, n_prim, r_sec, n_sec, r_prev, n_prev;
    logic [7:0]  r_status [CHANNELS];
    logic [31:0] r_tstamp, n_tstamp;
    logic        r_relclk, n_relclk, r_reldat, n_reldat;

    logic        st_we;
    logic [CW-1:0] st_idx;
    logic [7:0]  st_val;

    logic [2:0]  n_req;
    logic [7:0]  n_rsec, n_rdata;
    logic        r_ov;

    logic        wr_en;
    logic        accept;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_ready = !r_ov || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_ov;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            sbdp_pkg::REG_DEVNUM: prdata = {28'd0, r_devnum};
            sbdp_pkg::REG_ENABLE: prdata = {31'd0, r_enabled};
            default: prdata = '0;
        endcase
    end

    function automatic logic waited(input logic [31:0] now, input logic [31:0] ts,
                                    input logic [31:0] us);
        logic [31:0] d;
        d = now - ts;
        return d >= us;
    endfunction

    // Protocol step for one sample.
    always_comb begin
        logic [7:0]  pa_l, pa_t, sec;
        logic [CW-1:0] c;
        logic [7:0]  cst;
        logic        addressed, rdy;
        logic [2:0]  bi;
        n_phase = r_phase; n_talk = r_talk; n_listen = r_listen; n_atn = r_atn;
        n_shift = r_shift; n_prim = r_prim; n_sec = r_sec; n_prev = r_prev;
        n_tstamp = r_tstamp; n_relclk = r_relclk; n_reldat = r_reldat;
        n_req = sbdp_pkg::REQ_NONE; n_rsec = '0; n_rdata = '0;
        st_we = 1'b0; st_idx = '0; st_val = '0;
        pa_l = 8'h20 + {4'd0, r_devnum};
        pa_t = 8'h40 + {4'd0, r_devnum};
        sec = r_sec; c = '0; cst = '0; addressed = 1'b0; rdy = 1'b0;
        bi = '0;

        if (!r_atn && !i_atn_line) begin
            n_phase = sbdp_pkg::PH_PRE0; n_atn = 1'b1; n_prim = '0;
            n_prev = r_sec; n_sec = '0; n_tstamp = i_time_now;
            n_relclk = 1'b1; n_reldat = 1'b0;
        end else if (r_atn && i_atn_line) begin
            n_atn = 1'b0;
            addressed = (r_prim == pa_l) || (r_prim == pa_t);
            if (addressed) begin
                c = sec[CW-1:0];
                cst = r_status[c];
                if (sec[7:4] == sbdp_pkg::SEC_DATA) begin
                    n_req = sbdp_pkg::REQ_LISTALK; n_rsec = sec;
                end else if (sec[7:4] == sbdp_pkg::SEC_CLOSE) begin
                    n_req = sbdp_pkg::REQ_CLOSE; n_rsec = sec;
                    st_we = 1'b1; st_idx = c; st_val = i_host_status; cst = i_host_status;
                end else if (sec[7:4] == sbdp_pkg::SEC_OPEN) begin
                    n_req = sbdp_pkg::REQ_OPEN; n_rsec = sec;
                    st_we = 1'b1; st_idx = c; st_val = i_host_status; cst = i_host_status;
                end
                if (r_prim == pa_l) begin
                    n_talk = 1'b0;
                    if (cst == sbdp_pkg::ST_OK) begin
                        n_listen = 1'b1; n_phase = sbdp_pkg::PH_PRE1;
                    end
                    n_relclk = 1'b1; n_reldat = 1'b0;
                end else begin
                    n_listen = 1'b0; n_talk = 1'b1; n_phase = sbdp_pkg::PH_PRE0;
                end
            end else if (r_prim == sbdp_pkg::ADDR_UNLISTEN && r_listen) begin
                n_listen = 1'b0;
                n_req = sbdp_pkg::REQ_UNLISTEN; n_rsec = r_prev;
                st_we = 1'b1; st_idx = r_prev[CW-1:0]; st_val = i_host_status;
            end else if (r_prim == sbdp_pkg::ADDR_UNTALK && r_talk) begin
                n_req = sbdp_pkg::REQ_UNTALK; n_rsec = r_prev; n_talk = 1'b0;
            end
            if (!n_listen && !n_talk) begin
                n_relclk = 1'b1; n_reldat = 1'b1;
            end
        end

        bi = 3'((n_phase - sbdp_pkg::PH_BIT0) >> 1);
        if (n_atn || n_listen) begin
            case (n_phase)
                sbdp_pkg::PH_PRE0: begin
                    if (waited(i_time_now, n_tstamp, sbdp_pkg::T_PRE))
                        n_phase = sbdp_pkg::PH_PRE1;
                end
                sbdp_pkg::PH_PRE1: begin
                    if (!i_clk_line) n_phase = sbdp_pkg::PH_PRE2;
                end
                sbdp_pkg::PH_PRE2: begin
                    if (i_clk_line) begin
                        n_relclk = 1'b1; n_reldat = 1'b1;
                        n_tstamp = i_time_now; n_phase = sbdp_pkg::PH_READY;
                    end
                end
                sbdp_pkg::PH_READY: begin
                    if (!i_clk_line) begin
                        n_phase = sbdp_pkg::PH_BIT0;
                    end else if (!n_atn &&
                                 waited(i_time_now, n_tstamp, sbdp_pkg::T_READY)) begin
                        n_relclk = 1'b1; n_reldat = 1'b0;
                        n_phase = sbdp_pkg::PH_EOI; n_tstamp = i_time_now;
                    end
                end
                sbdp_pkg::PH_EOI: begin
                    if (waited(i_time_now, n_tstamp, sbdp_pkg::T_EOI)) begin
                        n_relclk = 1'b1; n_reldat = 1'b1; n_phase = sbdp_pkg::PH_EOIW;
                    end
                end
                sbdp_pkg::PH_EOIW: begin
                    if (!i_clk_line) n_phase = sbdp_pkg::PH_BIT0;
                end
                sbdp_pkg::PH_BIT7W: begin
                    if (!i_clk_line) begin
                        if (n_atn) begin
                            if (n_prim == 8'd0) n_prim = n_shift;
                            else if (n_sec == 8'd0) n_sec = n_shift;
                            if (!n_prim[4] && n_prim[3:0] != r_devnum) begin
                                n_phase = sbdp_pkg::PH_DONE0;
                            end else begin
                                n_relclk = 1'b1; n_reldat = 1'b0;
                                n_phase = sbdp_pkg::PH_PRE2;
                            end
                        end else if (n_req == sbdp_pkg::REQ_NONE) begin
                            n_req = sbdp_pkg::REQ_WRITE; n_rsec = n_sec; n_rdata = n_shift;
                            st_we = 1'b1; st_idx = n_sec[CW-1:0]; st_val = i_host_status;
                            if (i_host_status != sbdp_pkg::ST_OK) begin
                                n_phase = sbdp_pkg::PH_DONE0;
                            end else begin
                                n_relclk = 1'b1; n_reldat = 1'b0;
                                n_phase = sbdp_pkg::PH_PRE2;
                            end
                        end
                    end
                end
                default: begin
                    if (n_phase >= sbdp_pkg::PH_BIT0 && n_phase < sbdp_pkg::PH_BIT7W) begin
                        if (!n_phase[0]) begin
                            if (i_clk_line) begin
                                n_shift[bi] = i_data_line;
                                n_phase = n_phase + 5'd1;
                            end
                        end else if (!i_clk_line) begin
                            n_phase = n_phase + 5'd1;
                        end
                    end
                end
            endcase
        end else if (n_talk) begin
            case (n_phase)
                sbdp_pkg::PH_PRE0: begin
                    if (i_clk_line) begin
                        n_relclk = 1'b0; n_reldat = 1'b1;
                        n_phase = sbdp_pkg::PH_PRE1; n_tstamp = i_time_now;
                    end
                end
                sbdp_pkg::PH_PRE1: begin
                    if (waited(i_time_now, n_tstamp, sbdp_pkg::T_TALKW)) begin
                        n_relclk = 1'b1; n_reldat = 1'b1; n_phase = sbdp_pkg::PH_READY;
                    end else begin
                        rdy = 1'b1;
                    end
                end
                sbdp_pkg::PH_READY: rdy = 1'b1;
                sbdp_pkg::PH_EOI: begin
                    if (!i_data_line) n_phase = sbdp_pkg::PH_EOIW;
                end
                sbdp_pkg::PH_EOIW: begin
                    if (i_data_line) begin
                        n_phase = sbdp_pkg::PH_BIT0;
                        n_tstamp = i_time_now - sbdp_pkg::T_PRELOAD;
                    end
                end
                sbdp_pkg::PH_DONE0: begin
                    if (waited(i_time_now, n_tstamp, sbdp_pkg::T_BIT)) begin
                        n_relclk = 1'b0; n_reldat = 1'b1;
                        n_tstamp = i_time_now; n_phase = sbdp_pkg::PH_DONE1;
                    end
                end
                sbdp_pkg::PH_DONE1: begin
                    if (!i_data_line) begin
                        c = n_sec[CW-1:0];
                        if (r_status[c] == sbdp_pkg::ST_EOF) begin
                            n_talk = 1'b0;
                            st_we = 1'b1; st_idx = c; st_val = sbdp_pkg::ST_OK;
                            n_relclk = 1'b1; n_reldat = 1'b1;
                        end else begin
                            n_tstamp = i_time_now; n_phase = sbdp_pkg::PH_PRE1;
                        end
                    end else if (waited(i_time_now, n_tstamp, sbdp_pkg::T_ACK)) begin
                        n_relclk = 1'b1; n_reldat = 1'b1;
                        n_tstamp = i_time_now; n_phase = sbdp_pkg::PH_FERR0;
                    end
                end
                sbdp_pkg::PH_FERR0: begin
                    if (waited(i_time_now, n_tstamp, sbdp_pkg::T_FERR)) begin
                        n_relclk = 1'b0; n_reldat = 1'b1; n_phase = sbdp_pkg::PH_FERR1;
                    end
                end
                sbdp_pkg::PH_FERR1: begin
                    if (!i_data_line) begin
                        n_tstamp = i_time_now; n_phase = sbdp_pkg::PH_PRE1;
                    end
                end
                default: begin
                    if (n_phase >= sbdp_pkg::PH_BIT0 && n_phase <= sbdp_pkg::PH_BIT7W) begin
                        if (waited(i_time_now, n_tstamp, sbdp_pkg::T_BIT)) begin
                            if (!n_phase[0]) begin
                                n_relclk = 1'b0; n_reldat = n_shift[bi];
                            end else begin
                                n_relclk = 1'b1; n_reldat = i_data_line;
                            end
                            n_tstamp = i_time_now;
                            n_phase = n_phase + 5'd1;
                        end
                    end
                end
            endcase
            if (rdy && i_data_line && n_req == sbdp_pkg::REQ_NONE) begin
                n_req = sbdp_pkg::REQ_READ; n_rsec = n_sec;
                n_shift = i_host_byte;
                st_we = 1'b1; st_idx = n_sec[CW-1:0]; st_val = i_host_status;
                if (i_host_status == sbdp_pkg::ST_OK) begin
                    n_phase = sbdp_pkg::PH_BIT0;
                    n_tstamp = i_time_now - sbdp_pkg::T_PRELOAD;
                end else if (i_host_status == sbdp_pkg::ST_EOF) begin
                    n_phase = sbdp_pkg::PH_EOI; n_tstamp = i_time_now;
                end else begin
                    n_talk = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_devnum <= 4'd8; r_enabled <= 1'b0;
            r_phase <= sbdp_pkg::PH_PRE0;
            r_talk <= 1'b0; r_listen <= 1'b0; r_atn <= 1'b0;
            r_shift <= '0; r_prim <= '0; r_sec <= '0; r_prev <= '0;
            r_tstamp <= '0; r_relclk <= 1'b1; r_reldat <= 1'b1;
            r_ov <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) r_status[k] <= '0;
        end else begin
            if (wr_en && paddr[2] == sbdp_pkg::REG_DEVNUM) r_devnum <= pwdata[3:0];
            if (wr_en && paddr[2] == sbdp_pkg::REG_ENABLE) begin
                if (pwdata[0] && !r_enabled) begin
                    r_talk <= 1'b0; r_listen <= 1'b0; r_atn <= 1'b0;
                    for (int k = 0; k < CHANNELS; k++) r_status[k] <= '0;
                end else if (!pwdata[0] && r_enabled) begin
                    r_relclk <= 1'b1; r_reldat <= 1'b1;
                end
                r_enabled <= pwdata[0];
            end
            if (accept) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (accept && r_enabled) begin
                r_phase <= n_phase; r_talk <= n_talk; r_listen <= n_listen;
                r_atn <= n_atn; r_shift <= n_shift; r_prim <= n_prim;
                r_sec <= n_sec; r_prev <= n_prev; r_tstamp <= n_tstamp;
                r_relclk <= n_relclk; r_reldat <= n_reldat;
                if (st_we) r_status[st_idx] <= st_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_enabled) begin
                o_clk_release <= n_relclk; o_data_release <= n_reldat;
                o_host_request <= n_req; o_request_secondary <= n_rsec;
                o_request_data <= n_rdata; o_is_listening <= n_listen;
                o_is_talking <= n_talk;
            end else begin
                o_clk_release <= 1'b1; o_data_release <= 1'b1;
                o_host_request <= sbdp_pkg::REQ_NONE; o_request_secondary <= '0;
                o_request_data <= '0; o_is_listening <= 1'b0; o_is_talking <= 1'b0;
            end
        end
    end
endmodule

### sv/sbdp_checker.sv
// ----------------------------------------------------------------------------
// Serial bus device port checker
// Port-level properties of the serial bus device, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_bus_device_protocol_assert.svh"
module sbdp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic [2:0] o_host_request,
    input logic [7:0] o_request_data,
    input logic       o_is_listening,
    input logic       o_is_talking
);
    `SBD_ASSERT_IMP(a_mode_excl, i_clk, i_rst_n, o_valid, !(o_is_listening && o_is_talking), "listen and talk both set")
    `SBD_ASSERT_IMP(a_data_only_write, i_clk, i_rst_n, o_valid && o_host_request != sbdp_pkg::REQ_WRITE, o_request_data == 8'd0, "data byte without write request")
    `SBD_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, i_valid && o_ready, o_valid, "accepted sample gave no result")
    `SBD_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready, "not ready with empty output")
endmodule

bind serial_bus_device_protocol sbdp_checker u_sbdp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .o_host_request(o_host_request),
    .o_request_data(o_request_data), .o_is_listening(o_is_listening),
    .o_is_talking(o_is_talking)
);
